// ===== rtl/lmts_pkg.sv =====
// Shared types, codes and reset values for the LCD mode timing sequencer.
`timescale 1ns / 1ps

package lmts_pkg;

  // Status mode codes as seen on the mode output
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_VRAM   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_OAM_TICKS        = 3'd0;
  localparam logic [2:0] REG_VRAM_TICKS       = 3'd1;
  localparam logic [2:0] REG_HBLANK_TICKS     = 3'd2;
  localparam logic [2:0] REG_LINE_TICKS       = 3'd3;
  localparam logic [2:0] REG_FIRST_BLANK_LINE = 3'd4;
  localparam logic [2:0] REG_LAST_LINE        = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_OAM_TICKS        = 8'd83;
  localparam logic [7:0] RST_VRAM_TICKS       = 8'd169;
  localparam logic [7:0] RST_HBLANK_TICKS     = 8'd207;
  localparam logic [8:0] RST_LINE_TICKS       = 9'd456;
  localparam logic [7:0] RST_FIRST_BLANK_LINE = 8'd144;
  localparam logic [7:0] RST_LAST_LINE        = 8'd153;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_VRAM   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [7:0] oam_ticks;
    logic [7:0] vram_ticks;
    logic [7:0] hblank_ticks;
    logic [8:0] line_ticks;
    logic [7:0] first_blank_line;
    logic [7:0] last_line;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       draw_valid;
    logic [7:0] draw_row;
    logic       vblank_irq;
    logic       frame_ready;
    logic       frame_end;
  } res_t;

  function automatic logic [1:0] mode_code(state_t st);
    logic [1:0] code;
    case (st)
      ST_HBLANK: code = MODE_HBLANK;
      ST_OAM:    code = MODE_OAM;
      ST_VRAM:   code = MODE_VRAM;
      default:   code = MODE_VBLANK;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/lmts_cfg.sv =====
// Timing configuration registers with their reset values.
`timescale 1ns / 1ps

module lmts_cfg
  import lmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.oam_ticks        <= RST_OAM_TICKS;
      cfg.vram_ticks       <= RST_VRAM_TICKS;
      cfg.hblank_ticks     <= RST_HBLANK_TICKS;
      cfg.line_ticks       <= RST_LINE_TICKS;
      cfg.first_blank_line <= RST_FIRST_BLANK_LINE;
      cfg.last_line        <= RST_LAST_LINE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OAM_TICKS:        cfg.oam_ticks        <= cfg_data[7:0];
        REG_VRAM_TICKS:       cfg.vram_ticks       <= cfg_data[7:0];
        REG_HBLANK_TICKS:     cfg.hblank_ticks     <= cfg_data[7:0];
        REG_LINE_TICKS:       cfg.line_ticks       <= cfg_data[8:0];
        REG_FIRST_BLANK_LINE: cfg.first_blank_line <= cfg_data[7:0];
        REG_LAST_LINE:        cfg.last_line        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lmts_seq.sv =====
// Mode/line sequencer: state registers and the per-tick next-state logic.
`timescale 1ns / 1ps

module lmts_seq
  import lmts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic lcd_on,
  input  cfg_t cfg,
  output res_t res
);

  state_t     st, st_next;
  logic [7:0] line_cnt, line_cnt_next;
  logic       restart, restart_next;
  logic [7:0] oam_cnt, oam_cnt_next;
  logic [7:0] vram_cnt, vram_cnt_next;
  logic [7:0] hb_cnt, hb_cnt_next;
  logic [8:0] vb_cnt, vb_cnt_next;
  logic [7:0] held;

  always_comb begin
    st_next       = st;
    line_cnt_next = line_cnt;
    restart_next  = restart;
    oam_cnt_next  = oam_cnt;
    vram_cnt_next = vram_cnt;
    hb_cnt_next   = hb_cnt;
    vb_cnt_next   = vb_cnt;
    held          = line_cnt;
    res.draw_valid  = 1'b0;
    res.draw_row    = 8'd0;
    res.vblank_irq  = 1'b0;
    res.frame_ready = 1'b0;
    res.frame_end   = 1'b0;

    if (!lcd_on) begin
      st_next       = ST_VBLANK;
      line_cnt_next = 8'd0;
      restart_next  = 1'b1;
    end else begin
      // display turned back on, or a frame ended: start a fresh frame
      if (line_cnt == 8'd0 && restart) begin
        restart_next  = 1'b0;
        st_next       = ST_OAM;
        oam_cnt_next  = 8'd0;
        vram_cnt_next = 8'd0;
        hb_cnt_next   = 8'd0;
        vb_cnt_next   = 9'd0;
      end
      case (st_next)
        ST_OAM: begin
          oam_cnt_next = oam_cnt_next + 8'd1;
          if (oam_cnt_next >= cfg.oam_ticks) begin
            st_next       = ST_VRAM;
            vram_cnt_next = 8'd0;
          end
        end
        ST_VRAM: begin
          vram_cnt_next = vram_cnt_next + 8'd1;
          if (vram_cnt_next >= cfg.vram_ticks) begin
            st_next     = ST_HBLANK;
            hb_cnt_next = 8'd0;
          end
        end
        ST_HBLANK: begin
          hb_cnt_next = hb_cnt_next + 8'd1;
          if (hb_cnt_next >= cfg.hblank_ticks) begin
            res.draw_valid = 1'b1;
            res.draw_row   = line_cnt_next;
            line_cnt_next  = line_cnt_next + 8'd1;
            st_next        = ST_OAM;
            oam_cnt_next   = 8'd0;
          end
          // compared against the line after any step this tick
          if (line_cnt_next >= cfg.first_blank_line) begin
            res.vblank_irq  = 1'b1;
            res.frame_ready = 1'b1;
            st_next         = ST_VBLANK;
            vb_cnt_next     = 9'd0;
          end
        end
        default: begin
          held        = line_cnt_next;
          vb_cnt_next = vb_cnt_next + 9'd1;
          if (vb_cnt_next >= cfg.line_ticks) begin
            vb_cnt_next   = 9'd0;
            line_cnt_next = held + 8'd1;
          end
          // frame end looks at the line held at tick start
          if (held > cfg.last_line) begin
            res.frame_end = 1'b1;
            restart_next  = 1'b1;
            line_cnt_next = 8'd0;
            st_next       = ST_OAM;
            oam_cnt_next  = 8'd0;
          end
        end
      endcase
    end

    res.mode = mode_code(st_next);
    res.line = line_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_OAM;
      line_cnt <= 8'd0;
      restart  <= 1'b0;
      oam_cnt  <= 8'd0;
      vram_cnt <= 8'd0;
      hb_cnt   <= 8'd0;
      vb_cnt   <= 9'd0;
    end else if (step) begin
      st       <= st_next;
      line_cnt <= line_cnt_next;
      restart  <= restart_next;
      oam_cnt  <= oam_cnt_next;
      vram_cnt <= vram_cnt_next;
      hb_cnt   <= hb_cnt_next;
      vb_cnt   <= vb_cnt_next;
    end
  end

endmodule

// ===== rtl/lmts_obuf.sv =====
// Result register with a skid stage so input keeps flowing under output stall.
`timescale 1ns / 1ps

module lmts_obuf
  import lmts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t res_in,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t res_out
);

  logic skid_valid;
  res_t skid;
  logic out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= skid_valid || push || !out_free;
      if (out_free) begin
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_out <= skid_valid ? skid : res_in;
    end
    if (push && !out_free) begin
      skid <= res_in;
    end
  end

endmodule

// ===== rtl/lcd_mode_timing_sequencer_unit.sv =====
// Top level of the LCD mode timing sequencer.
`timescale 1ns / 1ps

// One input word per dot-clock tick; each word yields exactly one registered
// result word. The block takes a word every cycle: the next-state logic is
// combinational from the sequencer registers, and a result register plus one
// skid entry hold results while the output stalls, so in_ready drops only
// when both are full. Configuration writes take effect on the following cycle
// and should be made while no words are in flight.

module lcd_mode_timing_sequencer_unit
  import lmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  lcd_on,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            mode,
  output logic [7:0]            line,
  output logic                  draw_valid,
  output logic [7:0]            draw_row,
  output logic                  vblank_irq,
  output logic                  frame_ready,
  output logic                  frame_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t res_c;
  res_t res_q;
  logic step;

  assign step = in_valid && in_ready;

  lmts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmts_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .lcd_on (lcd_on),
    .cfg    (cfg),
    .res    (res_c)
  );

  lmts_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .res_in    (res_c),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign mode        = res_q.mode;
  assign line        = res_q.line;
  assign draw_valid  = res_q.draw_valid;
  assign draw_row    = res_q.draw_row;
  assign vblank_irq  = res_q.vblank_irq;
  assign frame_ready = res_q.frame_ready;
  assign frame_end   = res_q.frame_end;

endmodule

// ===== rtl/lmts_chk.sv =====
// Port-level checks for the LCD mode timing sequencer, bound to the top level.
`timescale 1ns / 1ps

module lmts_chk
  import lmts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] mode,
  input logic [7:0] line,
  input logic       draw_valid,
  input logic [7:0] draw_row,
  input logic       vblank_irq,
  input logic       frame_ready,
  input logic       frame_end
);

  // no draw request means a zero row
  a_row_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !draw_valid |-> draw_row == 8'd0)
    else $error("draw_row nonzero without draw_valid");

  // vblank entry raises both pulses and reports vblank mode
  a_irq_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |-> frame_ready && mode == MODE_VBLANK)
    else $error("vblank entry word inconsistent");

  // frame end restarts at line 0 in oam read
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> line == 8'd0 && mode == MODE_OAM && !vblank_irq)
    else $error("frame end word inconsistent");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(line))
    else $error("stalled result word changed");

endmodule

bind lcd_mode_timing_sequencer_unit lmts_chk u_lmts_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .mode        (mode),
  .line        (line),
  .draw_valid  (draw_valid),
  .draw_row    (draw_row),
  .vblank_irq  (vblank_irq),
  .frame_ready (frame_ready),
  .frame_end   (frame_end)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the LCD mode timing sequencer.
`timescale 1ns / 1ps

module tb;
  import lmts_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  lcd_on = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            mode;
  logic [7:0]            line;
  logic                  draw_valid;
  logic [7:0]            draw_row;
  logic                  vblank_irq;
  logic                  frame_ready;
  logic                  frame_end;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // timing shadow: config and sequencer state as the block should hold them
  cfg_t       timing_cfg = '{8'd83, 8'd169, 8'd207, 9'd456, 8'd144, 8'd153};
  logic [1:0] t_mode = MODE_OAM;
  logic [7:0] t_line = 8'd0;
  logic       t_restart = 1'b0;
  logic [7:0] t_oam = 8'd0;
  logic [7:0] t_vram = 8'd0;
  logic [7:0] t_hb = 8'd0;
  logic [8:0] t_vb = 9'd0;

  res_t pending_results[$];
  int   errors = 0;
  int   cycle_count = 0;
  int   hold_off = 0;
  int   tx_steady = 0;

  lcd_mode_timing_sequencer_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .lcd_on(lcd_on),
    .out_valid(out_valid), .out_ready(out_ready),
    .mode(mode), .line(line), .draw_valid(draw_valid), .draw_row(draw_row),
    .vblank_irq(vblank_irq), .frame_ready(frame_ready), .frame_end(frame_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10;
    clk = 1'b1;
    #10;
    clk = 1'b0;
  end

  // Advance the timing shadow by one dot tick and return the result word.
  function automatic res_t step_timing(logic on);
    res_t       r;
    logic [7:0] held;
    r = '0;
    if (!on) begin
      t_mode = MODE_VBLANK;
      t_line = 8'd0;
      t_restart = 1'b1;
    end else begin
      if (t_line == 8'd0 && t_restart) begin
        t_restart = 1'b0;
        t_mode = MODE_OAM;
        t_oam = 8'd0;
        t_vram = 8'd0;
        t_hb = 8'd0;
        t_vb = 9'd0;
      end
      case (t_mode)
        MODE_OAM: begin
          t_oam = t_oam + 8'd1;
          if (t_oam >= timing_cfg.oam_ticks) begin
            t_mode = MODE_VRAM;
            t_vram = 8'd0;
          end
        end
        MODE_VRAM: begin
          t_vram = t_vram + 8'd1;
          if (t_vram >= timing_cfg.vram_ticks) begin
            t_mode = MODE_HBLANK;
            t_hb = 8'd0;
          end
        end
        MODE_HBLANK: begin
          t_hb = t_hb + 8'd1;
          if (t_hb >= timing_cfg.hblank_ticks) begin
            r.draw_valid = 1'b1;
            r.draw_row = t_line;
            t_line = t_line + 8'd1;
            t_mode = MODE_OAM;
            t_oam = 8'd0;
          end
          // entry is checked against the line after any step this tick
          if (t_line >= timing_cfg.first_blank_line) begin
            r.vblank_irq = 1'b1;
            r.frame_ready = 1'b1;
            t_mode = MODE_VBLANK;
            t_vb = 9'd0;
          end
        end
        default: begin
          held = t_line;
          t_vb = t_vb + 9'd1;
          if (t_vb >= timing_cfg.line_ticks) begin
            t_vb = 9'd0;
            t_line = held + 8'd1;
          end
          // frame end uses the line held at the start of the tick
          if (held > timing_cfg.last_line) begin
            r.frame_end = 1'b1;
            t_restart = 1'b1;
            t_line = 8'd0;
            t_mode = MODE_OAM;
            t_oam = 8'd0;
          end
        end
      endcase
    end
    r.mode = t_mode;
    r.line = t_line;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int next_gap(inout int steady);
    int r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady = $urandom_range(30, 100);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called at a rising edge; returns at a rising edge.
  task automatic send_tick(logic on, int gap);
    in_valid <= 1'b1;
    lcd_on <= on;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(step_timing(on));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_timing(cfg_t c);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_OAM_TICKS;
    cfg_data <= {1'b0, c.oam_ticks};
    @(posedge clk);
    cfg_index <= REG_VRAM_TICKS;
    cfg_data <= {1'b0, c.vram_ticks};
    @(posedge clk);
    cfg_index <= REG_HBLANK_TICKS;
    cfg_data <= {1'b0, c.hblank_ticks};
    @(posedge clk);
    cfg_index <= REG_LINE_TICKS;
    cfg_data <= c.line_ticks;
    @(posedge clk);
    cfg_index <= REG_FIRST_BLANK_LINE;
    cfg_data <= {1'b0, c.first_blank_line};
    @(posedge clk);
    cfg_index <= REG_LAST_LINE;
    cfg_data <= {1'b0, c.last_line};
    @(posedge clk);
    cfg_we <= 1'b0;
    timing_cfg = c;
    @(posedge clk);
  endtask

  // Reset timing: run, blank the LCD, then run again through the restart.
  task automatic test_power_cycle();
    for (int i = 0; i < 9; i++)
      send_tick((i < 4 || i > 5), next_gap(tx_steady));
  endtask

  // Tiny frame: zero OAM register, vblank entry, frame end and the restart after it.
  task automatic test_short_frame();
    load_timing('{8'd0, 8'd1, 8'd2, 9'd2, 8'd2, 8'd3});
    for (int i = 0; i < 18; i++) send_tick(1'b1, next_gap(tx_steady));
  endtask

  // last_line of 255 never ends the frame, so vblank runs the line past 255.
  task automatic test_line_wrap();
    load_timing('{8'd1, 8'd1, 8'd1, 9'd1, 8'd1, 8'd255});
    send_tick(1'b0, next_gap(tx_steady));
    for (int i = 0; i < 270; i++) send_tick(1'b1, next_gap(tx_steady));
    for (int i = 0; i < 2; i++) send_tick(1'b0, next_gap(tx_steady));
  endtask

  // Output held off while words keep coming: result and skid fill, input stalls.
  task automatic test_backpressure();
    load_timing('{8'd2, 8'd3, 8'd2, 9'd3, 8'd3, 8'd5});
    hold_off = 60;
    for (int i = 0; i < 20; i++) send_tick(1'b1, 0);
    drain();
  endtask

  task automatic test_random_phases();
    cfg_t c;
    logic on;
    int   off_left;
    off_left = 0;
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        c = '{8'd255, 8'd255, 8'd255, 9'd511, 8'd254, 8'd254};
      end else if (p == 4) begin
        c = '{8'd1, 8'd1, 8'd1, 9'd1, 8'd1, 8'd1};
      end else begin
        c.oam_ticks = 8'($urandom_range(1, 5));
        c.vram_ticks = 8'($urandom_range(1, 5));
        c.hblank_ticks = 8'($urandom_range(1, 5));
        c.line_ticks = 9'($urandom_range(1, 10));
        c.first_blank_line = 8'($urandom_range(1, 8));
        c.last_line = 8'($urandom_range(1, c.first_blank_line + 4));
      end
      load_timing(c);
      for (int i = 0; i < 22; i++) begin
        if (off_left > 0) begin
          on = 1'b0;
          off_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          on = 1'b0;
          off_left = $urandom_range(0, 3);
        end else begin
          on = 1'b1;
        end
        send_tick(on, next_gap(tx_steady));
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: mode %0d line %0d", mode, line);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("mode", int'(want.mode), int'(mode));
        check_field("line", int'(want.line), int'(line));
        check_field("draw_valid", int'(want.draw_valid), int'(draw_valid));
        check_field("draw_row", int'(want.draw_row), int'(draw_row));
        check_field("vblank_irq", int'(want.vblank_irq), int'(vblank_irq));
        check_field("frame_ready", int'(want.frame_ready), int'(frame_ready));
        check_field("frame_end", int'(want.frame_end), int'(frame_end));
      end
    end
  end

  // output side: long hold-off on request, else random stalls
  initial begin
    int stall_left;
    int rx_steady;
    stall_left = 0;
    rx_steady = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = next_gap(rx_steady);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lcd_mode_timing_sequencer_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_power_cycle();
    test_short_frame();
    test_line_wrap();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("lcd_mode_timing_sequencer_unit verification clean");
    end else begin
      $display("lcd_mode_timing_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
